// File: src/apfs_pkg.sv
// ----------------------------------------------------------------------------
// apfs_pkg
// Shared widths, register indexes, reset values and types for the analog
// position filter and scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apfs_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int POS_BITS      = 15;
    localparam int SHIFT_BITS    = 4;
    localparam int CFG_ADDR_BITS = 3;
    localparam int NUM_BITS      = SAMPLE_BITS + 1 + POS_BITS;
    localparam int STEP_CNT_BITS = $clog2(POS_BITS);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [SHIFT_BITS-1:0]  shift_t;
    typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

    localparam shift_t SHIFT_MAX = shift_t'(8);

    localparam sample_t LOW_RESET   = sample_t'(120);
    localparam sample_t HIGH_RESET  = sample_t'(3970);
    localparam shift_t  SHIFT_RESET = shift_t'(2);

    localparam cfg_addr_t CFG_LOW_X  = cfg_addr_t'(0);
    localparam cfg_addr_t CFG_HIGH_X = cfg_addr_t'(1);
    localparam cfg_addr_t CFG_LOW_Y  = cfg_addr_t'(2);
    localparam cfg_addr_t CFG_HIGH_Y = cfg_addr_t'(3);
    localparam cfg_addr_t CFG_SHIFT  = cfg_addr_t'(4);
    localparam cfg_addr_t CFG_FLIP_X = cfg_addr_t'(5);
    localparam cfg_addr_t CFG_FLIP_Y = cfg_addr_t'(6);

    localparam logic [STEP_CNT_BITS-1:0] LAST_STEP = STEP_CNT_BITS'(POS_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic filt;
        logic load;
        logic prep;
        logic step;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// File: src/apfs_lane.sv
// ----------------------------------------------------------------------------
// apfs_lane
// One axis: moving-average filter state, window clamp, scale by full range
// and a restoring divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apfs_lane import apfs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire lane_ctrl_t ctrl,
    input  wire sample_t    sample,
    input  wire shift_t     shift,
    input  wire sample_t    low,
    input  wire sample_t    high,
    input  wire logic       flip,
    output sample_t         smoothed,
    output pos_t            pos
);

    sample_t                 smoothed_reg, smoothed_next;
    logic [SAMPLE_BITS:0]    rem_reg, rem_next;
    logic [SAMPLE_BITS:0]    denom_reg, denom_next;
    pos_t                    quot_reg, quot_next;

    sample_t                 cur;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SAMPLE_BITS:0] delta;
    logic [SAMPLE_BITS:0]    sum;
    logic [SAMPLE_BITS:0]    lo_ext, hi_ext, v_ext, v_clamp, span;
    logic [NUM_BITS-1:0]     num;
    logic [SAMPLE_BITS+1:0]  trial;
    logic [SAMPLE_BITS+1:0]  trial_sub;
    logic                    ge;

    always_comb begin
        cur   = ctrl.load ? sample : smoothed_reg;
        diff  = $signed({1'b0, sample}) - $signed({1'b0, cur});
        delta = diff >>> shift;
        sum   = {1'b0, cur} + $unsigned(delta);
        smoothed_next = smoothed_reg;
        if (ctrl.filt) begin
            smoothed_next = (shift == '0) ? sample : sum[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        lo_ext = {1'b0, low};
        hi_ext = (high <= low) ? lo_ext + 1'b1 : {1'b0, high};
        v_ext  = {1'b0, smoothed_reg};
        if (v_ext < lo_ext) begin
            v_clamp = lo_ext;
        end else if (v_ext > hi_ext) begin
            v_clamp = hi_ext;
        end else begin
            v_clamp = v_ext;
        end
        span = v_clamp - lo_ext;
        num  = {span, {POS_BITS{1'b0}}} - {{POS_BITS{1'b0}}, span};

        trial     = {rem_reg, quot_reg[POS_BITS-1]};
        trial_sub = trial - {1'b0, denom_reg};
        ge        = (trial >= {1'b0, denom_reg});

        rem_next   = rem_reg;
        denom_next = denom_reg;
        quot_next  = quot_reg;
        if (ctrl.prep) begin
            rem_next   = num[NUM_BITS-1:POS_BITS];
            quot_next  = num[POS_BITS-1:0];
            denom_next = hi_ext - lo_ext;
        end else if (ctrl.step) begin
            rem_next  = ge ? trial_sub[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
            quot_next = {quot_reg[POS_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoothed_reg <= '0;
        end else begin
            smoothed_reg <= smoothed_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
        quot_reg  <= quot_next;
    end

    assign smoothed = smoothed_reg;
    assign pos      = flip ? ~quot_reg : quot_reg;

endmodule

`default_nettype wire

// File: src/analog_position_filter_scaler.sv
// ----------------------------------------------------------------------------
// analog_position_filter_scaler
// Two-axis moving-average filter with calibrated window scaling to 0..32767.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     s_sample_x, s_sample_y         s_valid / s_ready
//  result    m_pos_x, m_pos_y               m_valid / m_ready
//  config    cfg_addr, cfg_wdata            cfg_we, single cycle
//
//  m_valid rises once a sample transfer has passed every step: the filter
//  updates at the transfer edge, then ST_PREP clamps and scales, ST_DIV runs
//  the divider (one quotient bit per cycle in each lane) and ST_OUT loads the
//  output register, waiting while an earlier result is still not taken.
//  A new item is taken once the lanes are idle, even while a result waits.
//  Synchronous active-low reset restores the calibration and clears the control and filter state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module analog_position_filter_scaler import apfs_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire sample_t   s_sample_x,
    input  wire sample_t   s_sample_y,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pos_t           m_pos_x,
    output pos_t           m_pos_y,
    input  wire logic      cfg_we,
    input  wire cfg_addr_t cfg_addr,
    input  wire sample_t   cfg_wdata
);

    sample_t low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    shift_t  shift_reg;
    logic    flip_x_reg, flip_y_reg;

    state_t                   state_reg, state_next;
    logic [STEP_CNT_BITS-1:0] step_cnt_reg, step_cnt_next;
    logic                     m_valid_reg, m_valid_next;
    pos_t                     m_pos_x_reg, m_pos_y_reg;
    logic                     out_load;

    lane_ctrl_t ctrl;
    shift_t     shift_eff;
    sample_t    smoothed_x, smoothed_y;
    pos_t       lane_pos_x, lane_pos_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_x_reg  <= LOW_RESET;
            high_x_reg <= HIGH_RESET;
            low_y_reg  <= LOW_RESET;
            high_y_reg <= HIGH_RESET;
            shift_reg  <= SHIFT_RESET;
            flip_x_reg <= 1'b0;
            flip_y_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_LOW_X:  low_x_reg  <= cfg_wdata;
                CFG_HIGH_X: high_x_reg <= cfg_wdata;
                CFG_LOW_Y:  low_y_reg  <= cfg_wdata;
                CFG_HIGH_Y: high_y_reg <= cfg_wdata;
                CFG_SHIFT:  shift_reg  <= cfg_wdata[SHIFT_BITS-1:0];
                CFG_FLIP_X: flip_x_reg <= cfg_wdata[0];
                CFG_FLIP_Y: flip_y_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign shift_eff = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg;
        out_load      = 1'b0;
        s_ready       = 1'b0;
        ctrl          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.filt = s_valid;
                ctrl.load = (smoothed_x == '0) && (smoothed_y == '0);
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                ctrl.prep     = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                ctrl.step     = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST_STEP) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pos_x_reg <= lane_pos_x;
            m_pos_y_reg <= lane_pos_y;
        end
    end

    apfs_lane u_lane_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (s_sample_x),
        .shift    (shift_eff),
        .low      (low_x_reg),
        .high     (high_x_reg),
        .flip     (flip_x_reg),
        .smoothed (smoothed_x),
        .pos      (lane_pos_x)
    );

    apfs_lane u_lane_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sample   (s_sample_y),
        .shift    (shift_eff),
        .low      (low_y_reg),
        .high     (high_y_reg),
        .flip     (flip_y_reg),
        .smoothed (smoothed_y),
        .pos      (lane_pos_y)
    );

    assign m_valid = m_valid_reg;
    assign m_pos_x = m_pos_x_reg;
    assign m_pos_y = m_pos_y_reg;

endmodule

`default_nettype wire

// File: dv/apfs_position_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apfs_position_checker
// Monitors the sample, result and register ports of the position filter and
// scaler. It keeps its own filter state and calibration. For every sample
// transfer it predicts the scaled position pair, then compares each result
// transfer against the oldest prediction and counts mismatches and unexpected results.
// ----------------------------------------------------------------------------
module apfs_position_checker import apfs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  sample_t     s_sample_x,
    input  sample_t     s_sample_y,
    input  logic        m_valid,
    input  logic        m_ready,
    input  pos_t        m_pos_x,
    input  pos_t        m_pos_y,
    input  logic        cfg_we,
    input  cfg_addr_t   cfg_addr,
    input  sample_t     cfg_wdata,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam longint unsigned FULL_POS = (1 << POS_BITS) - 1;

    typedef struct packed {
        pos_t x;
        pos_t y;
    } pos_pair_t;

    sample_t     lo_x, hi_x, lo_y, hi_y;
    shift_t      shift_cfg;
    logic        inv_x, inv_y;
    sample_t     avg_x, avg_y;
    pos_pair_t   pos_expected_q[$];
    int unsigned errors = 0;

    function automatic sample_t ema_update(sample_t cur, sample_t raw, int unsigned sh);
        int diff;
        if (sh == 0) return raw;
        diff = int'(raw) - int'(cur);
        return sample_t'(int'(cur) + (diff >>> sh));
    endfunction

    function automatic pos_t window_scale(sample_t v, sample_t lo, sample_t hi, logic inv);
        longint unsigned val, lo_v, hi_v, q;
        val  = v;
        lo_v = lo;
        hi_v = hi;
        if (hi_v <= lo_v) hi_v = lo_v + 1;
        if (val < lo_v) val = lo_v;
        if (val > hi_v) val = hi_v;
        q = (val - lo_v) * FULL_POS / (hi_v - lo_v);
        if (q > FULL_POS) q = FULL_POS;
        if (inv) q = FULL_POS - q;
        return pos_t'(q);
    endfunction

    function automatic pos_pair_t predict_position(sample_t raw_x, sample_t raw_y);
        pos_pair_t   res;
        int unsigned sh;
        sh = (shift_cfg > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(shift_cfg);
        if (avg_x == '0 && avg_y == '0) begin
            avg_x = raw_x;
            avg_y = raw_y;
        end
        avg_x = ema_update(avg_x, raw_x, sh);
        avg_y = ema_update(avg_y, raw_y, sh);
        res.x = window_scale(avg_x, lo_x, hi_x, inv_x);
        res.y = window_scale(avg_y, lo_y, hi_y, inv_y);
        return res;
    endfunction

    always @(posedge aclk) begin
        pos_pair_t exp_pos;
        if (!aresetn) begin
            lo_x      = LOW_RESET;
            hi_x      = HIGH_RESET;
            lo_y      = LOW_RESET;
            hi_y      = HIGH_RESET;
            shift_cfg = SHIFT_RESET;
            inv_x     = 1'b0;
            inv_y     = 1'b0;
            avg_x     = '0;
            avg_y     = '0;
            pos_expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_LOW_X:  lo_x = cfg_wdata;
                    CFG_HIGH_X: hi_x = cfg_wdata;
                    CFG_LOW_Y:  lo_y = cfg_wdata;
                    CFG_HIGH_Y: hi_y = cfg_wdata;
                    CFG_SHIFT:  shift_cfg = cfg_wdata[SHIFT_BITS-1:0];
                    CFG_FLIP_X: inv_x = cfg_wdata[0];
                    CFG_FLIP_Y: inv_y = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pos_expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual pos_x %0d pos_y %0d",
                             $time, m_pos_x, m_pos_y);
                    errors++;
                end else begin
                    exp_pos = pos_expected_q.pop_front();
                    if (m_pos_x !== exp_pos.x) begin
                        $display("%0t: pos_x mismatch: expected %0d, actual %0d",
                                 $time, exp_pos.x, m_pos_x);
                        errors++;
                    end
                    if (m_pos_y !== exp_pos.y) begin
                        $display("%0t: pos_y mismatch: expected %0d, actual %0d",
                                 $time, exp_pos.y, m_pos_y);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                pos_expected_q.push_back(predict_position(s_sample_x, s_sample_y));
        end
        fail_count <= errors;
        pending    <= pos_expected_q.size();
    end

endmodule

// File: dv/tb_analog_position_filter_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_analog_position_filter_scaler
// Drives sample pairs and calibration writes into the position filter and
// scaler. A directed pass covers sample and window extremes, empty and
// reversed windows, large and zero shifts and the reload from zero. Random
// phases follow with new calibration each, random idling on both channels,
// a long result hold-off and a sender pause. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_analog_position_filter_scaler;
    import apfs_pkg::*;

    localparam int        SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int        NUM_PHASES      = 16;
    localparam int        ITEMS_PER_PHASE = 95;
    localparam int        SETTLE_CYCLES   = 24;
    localparam int        RX_HOLD_CYCLES  = 300;
    localparam int        CYCLE_LIMIT     = 400000;
    localparam cfg_addr_t CFG_UNUSED      = cfg_addr_t'(7);

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    sample_t     s_sample_x  = '0;
    sample_t     s_sample_y  = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    pos_t        m_pos_x;
    pos_t        m_pos_y;
    logic        cfg_we      = 1'b0;
    cfg_addr_t   cfg_addr    = '0;
    sample_t     cfg_wdata   = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_cnt   = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        rx_hold_req = 1'b0;
    sample_t     last_x      = '0;
    sample_t     last_y      = '0;
    sample_t     win_lo_x, win_hi_x, win_lo_y, win_hi_y;

    analog_position_filter_scaler u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_x (s_sample_x),
        .s_sample_y (s_sample_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pos_x    (m_pos_x),
        .m_pos_y    (m_pos_y),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    apfs_position_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_x (s_sample_x),
        .s_sample_y (s_sample_y),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pos_x    (m_pos_x),
        .m_pos_y    (m_pos_y),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("analog_position_filter_scaler regression: fail");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        forever begin
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_pair(input sample_t x, input sample_t y);
        int unsigned gap;
        gap = 0;
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_sample_x <= x;
        s_sample_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_x = x;
        last_y = y;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_addr_t addr, input sample_t data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_window(input cfg_addr_t lo_addr, input cfg_addr_t hi_addr,
                                output sample_t lo, output sample_t hi);
        case ($urandom_range(0, 5))
            0: begin
                lo = LOW_RESET;
                hi = HIGH_RESET;
            end
            1: begin
                lo = '0;
                hi = sample_t'(SAMPLE_MAX);
            end
            2: begin
                lo = sample_t'($urandom_range(0, 2047));
                hi = sample_t'($urandom_range(2048, SAMPLE_MAX));
            end
            3: begin
                lo = sample_t'($urandom_range(0, SAMPLE_MAX));
                hi = lo;
            end
            4: begin
                hi = sample_t'($urandom_range(0, 2047));
                lo = sample_t'($urandom_range(2048, SAMPLE_MAX));
            end
            default: begin
                lo = sample_t'($urandom_range(0, SAMPLE_MAX - 8));
                hi = lo + sample_t'($urandom_range(1, 8));
            end
        endcase
        write_reg(lo_addr, lo);
        write_reg(hi_addr, hi);
    endtask

    function automatic sample_t pick_sample(sample_t prev, sample_t lo, sample_t hi);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, SAMPLE_MAX);
            4, 5: v = ($urandom_range(0, 1) ? int'(hi) : int'(lo))
                      + int'($urandom_range(0, 6)) - 3;
            6, 7: v = int'(prev) + int'($urandom_range(0, 128)) - 64;
            default: v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        endcase
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return sample_t'(v);
    endfunction

    initial begin
        int      phase;
        int      n;
        int      shift_pick;
        shift_t  sh;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 30;
        rx_idle_pct = 30;

        // reset calibration, first pair loads the filter
        send_pair(12'hFFF, 12'h000);
        send_pair(12'h000, 12'hFFF);
        send_pair(12'd120, 12'd3970);
        send_pair(12'hFFF, 12'hFFF);
        send_pair(12'h000, 12'h000);

        // no filtering, full x window inverted, empty y window
        drain();
        write_reg(CFG_SHIFT, 12'hA50);
        write_reg(CFG_LOW_X, 12'h000);
        write_reg(CFG_HIGH_X, 12'hFFF);
        write_reg(CFG_FLIP_X, 12'h001);
        write_reg(CFG_LOW_Y, 12'd2000);
        write_reg(CFG_HIGH_Y, 12'd2000);
        write_reg(CFG_FLIP_Y, 12'hFFE);
        write_reg(CFG_UNUSED, 12'hFFF);
        send_pair(12'h000, 12'd1999);
        send_pair(12'hFFF, 12'd2000);
        send_pair(12'h800, 12'd2001);
        send_pair(12'h000, 12'h000);
        send_pair(12'h001, 12'hFFF);

        // reversed y window, shift nine acts as eight
        drain();
        write_reg(CFG_LOW_Y, 12'd3000);
        write_reg(CFG_HIGH_Y, 12'd100);
        write_reg(CFG_FLIP_Y, 12'h001);
        write_reg(CFG_SHIFT, 12'hFF9);
        send_pair(12'd100, 12'd2999);
        send_pair(12'hFFF, 12'd3000);
        send_pair(12'h000, 12'd3001);
        send_pair(12'd4000, 12'h000);

        // window pinned at the top, largest shift
        drain();
        write_reg(CFG_SHIFT, 12'h00F);
        write_reg(CFG_LOW_X, 12'hFFF);
        write_reg(CFG_HIGH_X, 12'hFFF);
        send_pair(12'hFFF, 12'hFFF);
        send_pair(12'hFFE, 12'h000);

        drain();
        write_reg(CFG_SHIFT, 12'h001);
        write_reg(CFG_HIGH_X, 12'h000);
        send_pair(12'h000, 12'h000);
        send_pair(12'hFFF, 12'h7FF);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            write_window(CFG_LOW_X, CFG_HIGH_X, win_lo_x, win_hi_x);
            write_window(CFG_LOW_Y, CFG_HIGH_Y, win_lo_y, win_hi_y);
            shift_pick = $urandom_range(0, 7);
            if (shift_pick < 2)
                sh = '0;
            else if (shift_pick < 6)
                sh = shift_t'($urandom_range(1, 8));
            else
                sh = shift_t'($urandom_range(9, 15));
            write_reg(CFG_SHIFT, {8'($urandom), sh});
            write_reg(CFG_FLIP_X, {11'($urandom), 1'($urandom)});
            write_reg(CFG_FLIP_Y, {11'($urandom), 1'($urandom)});
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, sample_t'($urandom));

            if (phase == NUM_PHASES - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = $urandom_range(0, 2) * 25;
                rx_idle_pct = $urandom_range(0, 2) * 25;
            end
            if (phase == 2)
                rx_hold_req = 1'b1;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 5 && n == ITEMS_PER_PHASE / 2)
                    drain();
                if ($urandom_range(0, 9) == 0)
                    send_pair('0, '0);
                else
                    send_pair(pick_sample(last_x, win_lo_x, win_hi_x),
                              pick_sample(last_y, win_lo_y, win_hi_y));
            end
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("analog_position_filter_scaler regression: pass");
        else
            $display("analog_position_filter_scaler regression: fail");
        $finish;
    end

endmodule
